>>> sv/serial_command_frame_splitter_macros.svh
// assertion macros for the serial command frame splitter checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SERIAL_COMMAND_FRAME_SPLITTER_MACROS_SVH
`define SERIAL_COMMAND_FRAME_SPLITTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SCFS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scfs same-cycle check failed");

// next-cycle implication, disabled while in reset
`define SCFS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scfs next-cycle check failed");

`endif

>>> sv/scfs_pkg.sv
// shared types, constants and helpers of the serial command frame splitter
// no dependencies
package scfs_pkg;

  localparam int CHUNK_MAX  = 64;
  localparam int ABSORB_MAX = 4;

  localparam int PosW   = $clog2(CHUNK_MAX + 1);
  localparam int StartW = $clog2(CHUNK_MAX);
  localparam int AbsW   = $clog2(ABSORB_MAX + 1);

  localparam logic [7:0] ChOpen  = 8'h23;  // '#'
  localparam logic [7:0] ChImu   = 8'h24;  // '$'
  localparam logic [7:0] ChExt   = 8'h40;  // '@'
  localparam logic [7:0] ChStar  = 8'h2a;  // '*'
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;

  typedef enum logic [2:0] {
    SEG_PASS    = 3'd0,
    SEG_IMU     = 3'd1,
    SEG_EXT     = 3'd2,
    SEG_CONSOLE = 3'd3,
    SEG_FWD     = 3'd4
  } seg_type_e;

  typedef struct packed {
    seg_type_e          seg_type;
    logic [StartW-1:0]  seg_start;
    logic [PosW-1:0]    seg_length;
    logic               last_of_item;
  } seg_desc_t;

  // descriptors produced by one byte
  typedef struct packed {
    logic [1:0]       cnt;
    seg_desc_t [1:0]  desc;
  } seg_pair_t;

  // append a descriptor, a third one is dropped
  function automatic seg_pair_t put_seg(seg_pair_t p, seg_type_e t,
                                        logic [StartW-1:0] s, logic [PosW-1:0] l);
    seg_pair_t r;
    r = p;
    if (p.cnt < 2'd2) begin
      r.desc[p.cnt[0]].seg_type     = t;
      r.desc[p.cnt[0]].seg_start    = s;
      r.desc[p.cnt[0]].seg_length   = l;
      r.desc[p.cnt[0]].last_of_item = 1'b0;
      r.cnt = p.cnt + 2'd1;
    end
    return r;
  endfunction

endpackage

>>> sv/scfs_ifs.sv
// valid/ready channel interfaces: input bytes and segment descriptors
// depends on scfs_pkg
interface scfs_byte_if;
  import scfs_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_last;

  modport source (output valid, output data_byte, output chunk_last, input ready);
  modport sink   (input valid, input data_byte, input chunk_last, output ready);
endinterface

interface scfs_seg_if;
  import scfs_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        seg_type;
  logic [StartW-1:0] seg_start;
  logic [PosW-1:0]   seg_length;
  logic              last_of_item;

  modport source (output valid, output seg_type, output seg_start, output seg_length,
                  output last_of_item, input ready);
  modport sink   (input valid, input seg_type, input seg_start, input seg_length,
                  input last_of_item, output ready);
endinterface

>>> sv/serial_command_frame_splitter.sv
// serial command frame splitter: one chunk byte in, up to two segment descriptors out
// Usage: bytes of a received chunk arrive on in_i (valid/ready), chunk_last set on
// the final byte. A '#' opens a frame, the next '$', '@' or '*' closes it, and up
// to ABSORB_MAX following CR/LF bytes are absorbed into it. Descriptors (type,
// start offset, length, last_of_item) leave on out_o, one per transfer, in order.
// cfg_we_i/cfg_wdata_i write console_mode; write it only while the block is idle.
// Descriptors of a byte are registered and visible the cycle after its transfer.
// Throughput: one byte per cycle while each byte yields at most one descriptor
// and the receiver is ready; a byte that yields two holds off the next byte until
// its first descriptor has left. The two-entry result register sets this figure.
// Bytes past CHUNK_MAX within a chunk are dropped; all parse state clears at
// the chunk end. Reset clears parse state, console_mode and the result register.
// When the receiver stalls, results hold on out_o and in_i.ready drops until the
// result register drains.
// depends on scfs_pkg, scfs_ifs, scfs_out_buf
module serial_command_frame_splitter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  scfs_byte_if.sink    in_i,
  scfs_seg_if.source   out_o
);
  import scfs_pkg::*;

  logic              console_q;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [StartW-1:0] frame_start_q, frame_start_d;
  logic [PosW-1:0]   seg_end_q, seg_end_d;
  logic              opener_q, opener_d;
  seg_type_e         pend_type_q, pend_type_d;
  logic [AbsW-1:0]   absorb_q, absorb_d;
  logic [PosW-1:0]   pend_len_q, pend_len_d;

  seg_pair_t res;
  logic      accept;
  logic      can_load;
  logic      active;
  logic      done;
  logic      is_crlf;
  logic      is_closer;
  logic [7:0] b;

  assign accept    = in_i.valid && can_load;
  assign in_i.ready = can_load;
  assign b         = in_i.data_byte;
  assign is_crlf   = (b == ChCr) || (b == ChLf);
  assign is_closer = (b == ChImu) || (b == ChExt) || (b == ChStar);
  assign active    = (pos_q < PosW'(CHUNK_MAX));

  always_comb begin
    pos_d         = pos_q;
    frame_start_d = frame_start_q;
    seg_end_d     = seg_end_q;
    opener_d      = opener_q;
    pend_type_d   = pend_type_q;
    absorb_d      = absorb_q;
    pend_len_d    = pend_len_q;
    res           = '0;
    done          = 1'b0;

    if (active) begin
      if (pend_type_q != SEG_PASS) begin
        if (is_crlf && (absorb_q < AbsW'(ABSORB_MAX))) begin
          absorb_d = absorb_q + AbsW'(1);
          // console frames consume the line end without counting it
          if (pend_type_q != SEG_CONSOLE) begin
            pend_len_d = pend_len_q + PosW'(1);
          end
          seg_end_d = pos_q + PosW'(1);
          done      = 1'b1;
          if (absorb_d >= AbsW'(ABSORB_MAX)) begin
            res         = put_seg(res, pend_type_d, frame_start_d, pend_len_d);
            pend_type_d = SEG_PASS;
            absorb_d    = '0;
            pend_len_d  = '0;
          end
        end else begin
          res         = put_seg(res, pend_type_d, frame_start_d, pend_len_d);
          pend_type_d = SEG_PASS;
          absorb_d    = '0;
          pend_len_d  = '0;
        end
      end

      if (!done) begin
        if (b == ChOpen) begin
          opener_d      = 1'b1;
          frame_start_d = pos_q[StartW-1:0];
        end else if (opener_q && is_closer) begin
          case (b)
            ChImu:   pend_type_d = SEG_IMU;
            ChExt:   pend_type_d = SEG_EXT;
            default: pend_type_d = console_q ? SEG_CONSOLE : SEG_FWD;
          endcase
          pend_len_d = pos_q - PosW'(frame_start_q) + PosW'(1);
          absorb_d   = '0;
          opener_d   = 1'b0;
          seg_end_d  = pos_q + PosW'(1);
        end else if (opener_q && (seg_end_d != PosW'(frame_start_q))) begin
          // text ahead of the open frame goes out as passthrough
          if (PosW'(frame_start_q) > seg_end_d) begin
            res = put_seg(res, SEG_PASS, seg_end_d[StartW-1:0],
                          PosW'(frame_start_q) - seg_end_d);
          end
          seg_end_d = PosW'(frame_start_q);
        end
      end
      pos_d = pos_q + PosW'(1);
    end

    if (in_i.chunk_last) begin
      if (pend_type_d != SEG_PASS) begin
        res = put_seg(res, pend_type_d, frame_start_d, pend_len_d);
      end
      if (seg_end_d < pos_d) begin
        res = put_seg(res, SEG_PASS, seg_end_d[StartW-1:0], pos_d - seg_end_d);
      end
      pos_d         = '0;
      frame_start_d = '0;
      seg_end_d     = '0;
      opener_d      = 1'b0;
      pend_type_d   = SEG_PASS;
      absorb_d      = '0;
      pend_len_d    = '0;
    end

    // cnt of one marks entry 0, cnt of two marks entry 1
    if (res.cnt != 2'd0) begin
      res.desc[res.cnt[1]].last_of_item = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      console_q     <= 1'b0;
      pos_q         <= '0;
      frame_start_q <= '0;
      seg_end_q     <= '0;
      opener_q      <= 1'b0;
      pend_type_q   <= SEG_PASS;
      absorb_q      <= '0;
      pend_len_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        console_q <= cfg_wdata_i;
      end
      if (accept) begin
        pos_q         <= pos_d;
        frame_start_q <= frame_start_d;
        seg_end_q     <= seg_end_d;
        opener_q      <= opener_d;
        pend_type_q   <= pend_type_d;
        absorb_q      <= absorb_d;
        pend_len_q    <= pend_len_d;
      end
    end
  end

  scfs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .load_data_i (res),
    .can_load_o  (can_load),
    .out_o       (out_o)
  );

endmodule

>>> sv/scfs_out_buf.sv
// two-entry result register that hands out the descriptors of one byte in order
// depends on scfs_pkg and scfs_seg_if
module scfs_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  scfs_pkg::seg_pair_t  load_data_i,
  output logic                 can_load_o,
  scfs_seg_if.source           out_o
);
  import scfs_pkg::*;

  logic [1:0]      cnt_q, cnt_d;
  seg_desc_t [1:0] slot_q, slot_d;
  logic            pop;

  assign pop        = (cnt_q != 2'd0) && out_o.ready;
  // a new byte may enter when the buffer is empty or drains this cycle
  assign can_load_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);

  always_comb begin
    cnt_d  = cnt_q;
    slot_d = slot_q;
    if (load_i) begin
      cnt_d  = load_data_i.cnt;
      slot_d = load_data_i.desc;
    end else if (pop) begin
      cnt_d     = cnt_q - 2'd1;
      slot_d[0] = slot_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.seg_type     = slot_q[0].seg_type;
  assign out_o.seg_start    = slot_q[0].seg_start;
  assign out_o.seg_length   = slot_q[0].seg_length;
  assign out_o.last_of_item = slot_q[0].last_of_item;

endmodule

>>> sv/scfs_checker.sv
// port-level checks for the serial command frame splitter, bound to the top level
// depends on scfs_pkg and serial_command_frame_splitter_macros.svh
`include "serial_command_frame_splitter_macros.svh"

module scfs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [scfs_pkg::StartW-1:0] seg_start_i,
  input logic [scfs_pkg::PosW-1:0]   seg_length_i,
  input logic                        last_of_item_i
);
  import scfs_pkg::*;

  `SCFS_ASSERT_NXT(out_hold_a, out_valid_i && !out_ready_i, out_valid_i)
  `SCFS_ASSERT_IMP(len_nonzero_a, out_valid_i, seg_length_i != '0)
  `SCFS_ASSERT_IMP(in_chunk_a, out_valid_i, (10'(seg_start_i) + 10'(seg_length_i)) <= 10'(CHUNK_MAX))
  // a byte is taken only when the shown descriptor is the final one and leaves now
  `SCFS_ASSERT_IMP(ready_drain_a, in_ready_i && out_valid_i, out_ready_i && last_of_item_i)

endmodule

bind serial_command_frame_splitter scfs_checker u_scfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .seg_start_i    (out_o.seg_start),
  .seg_length_i   (out_o.seg_length),
  .last_of_item_i (out_o.last_of_item)
);
